[rtl/nearest_scale_color_key_assert.svh]
// assertion macros shared by the scaler modules
`ifndef NEAREST_SCALE_COLOR_KEY_ASSERT_SVH
`define NEAREST_SCALE_COLOR_KEY_ASSERT_SVH

`ifndef NO_ASSERTIONS

// checked only while out of reset
`define NSCK_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error(msg);

// checked at every edge, reset included
`define NSCK_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) \
        else $error(msg);

`else

`define NSCK_ASSERT(label, clk, rstn, prop, msg)
`define NSCK_ASSERT_ALWAYS(label, clk, prop, msg)

`endif

`endif

[rtl/nsck_pkg.sv]
// types and constants of the nearest scaler with color key
package nsck_pkg;

    localparam int COORD_W   = 12;
    localparam int SRC_DIM_W = 9;
    localparam int DST_DIM_W = 13;
    localparam int CHAN_W    = 8;
    localparam int PIX_W     = 3 * CHAN_W;
    localparam int PROD_W    = DST_DIM_W + SRC_DIM_W;
    localparam int QUO_W     = SRC_DIM_W;
    localparam int CNT_W     = $clog2(QUO_W + 1);
    localparam int SRC_DIM_MAX = 511;

    localparam logic [CHAN_W-1:0] ALPHA_BASE = 8'hFF;

    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_READ  = 1'b1;

    localparam logic [2:0] REG_SRC_WIDTH  = 3'd0;
    localparam logic [2:0] REG_SRC_HEIGHT = 3'd1;
    localparam logic [2:0] REG_DST_WIDTH  = 3'd2;
    localparam logic [2:0] REG_DST_HEIGHT = 3'd3;
    localparam logic [2:0] REG_KEY_THRESH = 3'd4;
    localparam logic [2:0] REG_COLOR_OFFS = 3'd5;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_READ,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

[rtl/nsck_ram.sv]
// generic simple dual-port ram with registered read
module nsck_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 65536,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/nsck_div.sv]
// restoring divider, one quotient bit per cycle
`include "nearest_scale_color_key_assert.svh"

module nsck_div
    import nsck_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic [PROD_W-1:0]    dividend,
    input  logic [DST_DIM_W-1:0] divisor,
    output div_stat_t            stat,
    output logic [QUO_W-1:0]     quotient
);

    logic                 busy_reg;
    logic                 done_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic [PROD_W-1:0]    rem_reg;
    logic [PROD_W-1:0]    dsh_reg;
    logic [DST_DIM_W-1:0] div_reg;
    logic [QUO_W-1:0]     quo_reg;
    logic                 ge;

    assign ge = (rem_reg >= dsh_reg);

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= CNT_W'(QUO_W);
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    // datapath: trial subtract of the shifted divisor
    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= dividend;
            dsh_reg <= PROD_W'(divisor) << (QUO_W - 1);
            div_reg <= divisor;
            quo_reg <= '0;
        end else if (busy_reg) begin
            if (ge) begin
                rem_reg <= rem_reg - dsh_reg;
            end
            quo_reg <= {quo_reg[QUO_W-2:0], ge};
            dsh_reg <= dsh_reg >> 1;
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = quo_reg;

    `NSCK_ASSERT(a_rem_below_divisor, aclk, aresetn, done_reg |-> (rem_reg < PROD_W'(div_reg)), "remainder not below divisor")
    `NSCK_ASSERT(a_start_when_free, aclk, aresetn, start |-> !busy_reg, "divider started while busy")
    `NSCK_ASSERT(a_busy_done_excl, aclk, aresetn, !(busy_reg && done_reg), "divider busy and done together")

endmodule

[rtl/nearest_scale_color_key.sv]
// nearest scaler top level: frame store, coordinate dividers, color offset and key
//
//  channel  dir  handshake          payload
//  s_       in   s_tvalid/s_tready  tdata x,y,c0,c1,c2; tuser func
//  m_       out  m_tvalid/m_tready  tdata pixel word; tuser keyed
//  apb      in   psel/penable       six registers at 4*i, pready always high
//
//  a write item is handled at acceptance: the pixel goes straight to the frame store
//  a read item occupies the block through clamp, multiply, two 9-step
//    restoring dividers running side by side (one quotient bit a cycle), one
//    registered frame store read and the result load
//  reset clears control state only; the frame store holds garbage until written
//  the result register lets the next item in while a result waits on m_tready;
//    a read then holds in its final step until the result register is free
`include "nearest_scale_color_key_assert.svh"

module nearest_scale_color_key
    import nsck_pkg::*;
#(
    parameter int MAX_SRC_WIDTH  = 256,
    parameter int MAX_SRC_HEIGHT = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // input items
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // coord_x 11:0, coord_y 23:12, chan0 31:24, chan1 39:32, chan2 47:40
    input  logic [0:0]  s_tuser,   // func
    // result items
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // pixel_word 31:0
    output logic [0:0]  m_tuser    // keyed
);

    localparam int DEPTH  = MAX_SRC_WIDTH * MAX_SRC_HEIGHT;
    localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SW_CAP = (MAX_SRC_WIDTH < SRC_DIM_MAX) ? MAX_SRC_WIDTH : SRC_DIM_MAX;
    localparam int SH_CAP = (MAX_SRC_HEIGHT < SRC_DIM_MAX) ? MAX_SRC_HEIGHT : SRC_DIM_MAX;

    // configuration registers
    logic [SRC_DIM_W-1:0] src_w_reg;
    logic [SRC_DIM_W-1:0] src_h_reg;
    logic [DST_DIM_W-1:0] dst_w_reg;
    logic [DST_DIM_W-1:0] dst_h_reg;
    logic [CHAN_W-1:0]    thr_reg;
    logic [31:0]          offs_reg;

    logic       cfg_wr;
    logic [2:0] cfg_idx;

    assign pready  = 1'b1;
    assign cfg_idx = paddr[4:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            src_w_reg <= SRC_DIM_W'(256);
            src_h_reg <= SRC_DIM_W'(256);
            dst_w_reg <= DST_DIM_W'(256);
            dst_h_reg <= DST_DIM_W'(256);
            thr_reg   <= '0;
            offs_reg  <= '0;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_SRC_WIDTH:  src_w_reg <= pwdata[SRC_DIM_W-1:0];
                REG_SRC_HEIGHT: src_h_reg <= pwdata[SRC_DIM_W-1:0];
                REG_DST_WIDTH:  dst_w_reg <= pwdata[DST_DIM_W-1:0];
                REG_DST_HEIGHT: dst_h_reg <= pwdata[DST_DIM_W-1:0];
                REG_KEY_THRESH: thr_reg   <= pwdata[CHAN_W-1:0];
                REG_COLOR_OFFS: offs_reg  <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_SRC_WIDTH:  prdata = 32'(src_w_reg);
            REG_SRC_HEIGHT: prdata = 32'(src_h_reg);
            REG_DST_WIDTH:  prdata = 32'(dst_w_reg);
            REG_DST_HEIGHT: prdata = 32'(dst_h_reg);
            REG_KEY_THRESH: prdata = 32'(thr_reg);
            REG_COLOR_OFFS: prdata = offs_reg;
            default:        prdata = '0;
        endcase
    end

    // effective sizes: zero counts as one, source sizes saturate at the store size
    logic [SRC_DIM_W-1:0] sw;
    logic [SRC_DIM_W-1:0] sh;
    logic [DST_DIM_W-1:0] dw;
    logic [DST_DIM_W-1:0] dh;

    always_comb begin
        if (src_w_reg == '0) begin
            sw = SRC_DIM_W'(1);
        end else if (32'(src_w_reg) > 32'(SW_CAP)) begin
            sw = SRC_DIM_W'(SW_CAP);
        end else begin
            sw = src_w_reg;
        end
        if (src_h_reg == '0) begin
            sh = SRC_DIM_W'(1);
        end else if (32'(src_h_reg) > 32'(SH_CAP)) begin
            sh = SRC_DIM_W'(SH_CAP);
        end else begin
            sh = src_h_reg;
        end
        dw = (dst_w_reg == '0) ? DST_DIM_W'(1) : dst_w_reg;
        dh = (dst_h_reg == '0) ? DST_DIM_W'(1) : dst_h_reg;
    end

    // input fields
    logic              in_func;
    logic [COORD_W-1:0] in_x;
    logic [COORD_W-1:0] in_y;
    logic [CHAN_W-1:0]  in_c0;
    logic [CHAN_W-1:0]  in_c1;
    logic [CHAN_W-1:0]  in_c2;
    logic               in_acc;

    assign in_func = s_tuser[0];
    assign in_x    = s_tdata[11:0];
    assign in_y    = s_tdata[23:12];
    assign in_c0   = s_tdata[31:24];
    assign in_c1   = s_tdata[39:32];
    assign in_c2   = s_tdata[47:40];
    assign in_acc  = s_tvalid && s_tready;

    // sequencer
    state_t state_reg;
    state_t state_next;
    logic   div_start;
    logic   ram_re;
    logic   out_load;
    logic   out_free;
    logic   m_tvalid_reg;
    div_stat_t stat_x;
    div_stat_t stat_y;

    assign out_free = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        s_tready   = 1'b0;
        div_start  = 1'b0;
        ram_re     = 1'b0;
        out_load   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid && in_func == FUNC_READ) begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                div_start  = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                if (stat_x.done && stat_y.done) begin
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                ram_re     = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // clamp the output coordinates and flip the row at acceptance
    logic [DST_DIM_W-1:0] x_ext;
    logic [DST_DIM_W-1:0] y_ext;
    logic [DST_DIM_W-1:0] y_clamp;
    logic [COORD_W-1:0]   cx_reg;
    logic [DST_DIM_W-1:0] ry_reg;

    assign x_ext   = DST_DIM_W'(in_x);
    assign y_ext   = DST_DIM_W'(in_y);
    assign y_clamp = (y_ext >= dh) ? (dh - DST_DIM_W'(1)) : y_ext;

    always_ff @(posedge aclk) begin
        if (in_acc) begin
            cx_reg <= (x_ext >= dw) ? COORD_W'(dw - DST_DIM_W'(1)) : in_x;
            ry_reg <= dh - DST_DIM_W'(1) - y_clamp;
        end
    end

    // scale products feed the dividers, which register them
    logic [PROD_W-1:0] prod_x;
    logic [PROD_W-1:0] prod_y;
    logic [QUO_W-1:0]  quo_x;
    logic [QUO_W-1:0]  quo_y;

    assign prod_x = PROD_W'(cx_reg) * PROD_W'(sw);
    assign prod_y = PROD_W'(ry_reg) * PROD_W'(sh);

    nsck_div u_div_x (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (prod_x),
        .divisor  (dw),
        .stat     (stat_x),
        .quotient (quo_x)
    );

    nsck_div u_div_y (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (prod_y),
        .divisor  (dh),
        .stat     (stat_y),
        .quotient (quo_y)
    );

    // frame store; the sequencer keeps writes and reads in different cycles
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [AW-1:0] ram_raddr;
    logic [PIX_W-1:0] ram_rdata;
    logic [31:0]   waddr_full;
    logic [31:0]   raddr_full;

    assign ram_we = in_acc && (in_func == FUNC_WRITE)
                    && (32'(in_x) < 32'(MAX_SRC_WIDTH))
                    && (32'(in_y) < 32'(MAX_SRC_HEIGHT));
    // row-major address, row stride is the store width
    assign waddr_full = 32'(in_y) * 32'(MAX_SRC_WIDTH) + 32'(in_x);
    assign raddr_full = 32'(quo_y) * 32'(MAX_SRC_WIDTH) + 32'(quo_x);
    assign ram_waddr  = waddr_full[AW-1:0];
    assign ram_raddr  = raddr_full[AW-1:0];

    nsck_ram #(
        .WIDTH (PIX_W),
        .DEPTH (DEPTH)
    ) u_frame_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata ({in_c0, in_c1, in_c2}),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // offsets and color key on the stored pixel
    logic [CHAN_W-1:0] px_c0;
    logic [CHAN_W-1:0] px_c1;
    logic [CHAN_W-1:0] px_c2;
    logic              key_hit;
    logic [CHAN_W-1:0] alpha;
    logic [31:0]       pix_word_reg;
    logic              keyed_reg;

    assign px_c0   = ram_rdata[23:16];
    assign px_c1   = ram_rdata[15:8];
    assign px_c2   = ram_rdata[7:0];
    assign key_hit = (px_c0 < thr_reg) && (px_c1 < thr_reg) && (px_c2 < thr_reg);
    assign alpha   = key_hit ? '0 : (ALPHA_BASE + offs_reg[31:24]);

    always_ff @(posedge aclk) begin
        if (out_load) begin
            pix_word_reg <= {alpha,
                             px_c0 + offs_reg[7:0],
                             px_c1 + offs_reg[15:8],
                             px_c2 + offs_reg[23:16]};
            keyed_reg    <= key_hit;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = pix_word_reg;
    assign m_tuser[0] = keyed_reg;

    `NSCK_ASSERT(a_no_rw_overlap, aclk, aresetn, !(ram_we && ram_re), "frame store written during a read")
    `NSCK_ASSERT(a_result_from_done, aclk, aresetn, $rose(m_tvalid_reg) |-> $past(state_reg == ST_DONE), "result raised outside final step")
    `NSCK_ASSERT(a_lanes_in_step, aclk, aresetn, stat_x.done == stat_y.done, "divider lanes out of step")
    `NSCK_ASSERT_ALWAYS(a_reset_clears, aclk, !aresetn |=> (!m_tvalid_reg && state_reg == ST_IDLE), "reset left block busy")

endmodule

[test/tb_top.sv]
// testbench for the nearest scaler with color key: directed rows, random phases, scoreboard
`timescale 1ns / 1ps

module tb_top;
    import nsck_pkg::*;

    // store geometry used by the block instance
    localparam int SRC_MAX_W     = 256;
    localparam int SRC_MAX_H     = 256;
    localparam int STORE_ENTRIES = SRC_MAX_W * SRC_MAX_H;
    // largest size a 13-bit output size register can hold
    localparam int DST_DIM_TOP   = 8191;

    // idle margin after the last result, to let a read finish
    localparam int SETTLE_CYCLES  = 24;
    localparam int RX_HOLD_CYCLES = 300;
    localparam int NUM_PHASES     = 8;
    localparam int PHASE_ITERS    = 70;
    localparam int CYCLE_LIMIT    = 400000;

    // one input item
    typedef struct packed {
        logic        func;
        logic [11:0] x;
        logic [11:0] y;
        logic [7:0]  c0;
        logic [7:0]  c1;
        logic [7:0]  c2;
    } pixel_req_t;

    // one result item
    typedef struct packed {
        logic [31:0] word;
        logic        keyed;
    } pixel_result_t;

    // one row of the directed part: a register write or an item
    typedef struct packed {
        logic          is_reg;
        logic [2:0]    reg_idx;
        logic [31:0]   reg_val;
        pixel_req_t    req;
        logic          has_want;
        pixel_result_t want;
    } stim_row_t;

    // clock and reset
    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    always #10 aclk = ~aclk;

    // configuration port
    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [4:0]  paddr   = '0;
    logic [31:0] pwdata  = '0;
    logic [31:0] prdata;
    logic        pready;

    // input items
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata  = '0;  // coord_x 11:0, coord_y 23:12, chan0 31:24, chan1 39:32, chan2 47:40
    logic [0:0]  s_tuser  = '0;  // func

    // result items
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;        // pixel_word 31:0
    logic [0:0]  m_tuser;        // keyed

    nearest_scale_color_key #(
        .MAX_SRC_WIDTH  (SRC_MAX_W),
        .MAX_SRC_HEIGHT (SRC_MAX_H)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // mirror of the frame store and of which entries hold a written pixel
    logic [23:0] frame_mirror [STORE_ENTRIES];
    bit          store_written [STORE_ENTRIES];

    // mirror of the registers, reset values
    logic [8:0]  cfg_src_w   = 9'd256;
    logic [8:0]  cfg_src_h   = 9'd256;
    logic [12:0] cfg_dst_w   = 13'd256;
    logic [12:0] cfg_dst_h   = 13'd256;
    logic [7:0]  cfg_key_thr = 8'd0;
    logic [31:0] cfg_offs    = 32'd0;

    // results still owed by the block, oldest first
    pixel_result_t pixel_expect_q [$];
    pixel_result_t head_px;
    stim_row_t     stim_rows [$];

    int unsigned mismatch_count = 0;
    int unsigned cycle_count    = 0;

    // pacing knobs shared by the sender and the receiver
    bit          calm        = 1'b0;  // no idling at all
    bit          tx_rush     = 1'b0;  // sender offers back to back
    bit          rx_hold_req = 1'b0;  // receiver holds off for a long stretch
    int unsigned tx_idle_pct = 0;
    int unsigned rx_idle_pct = 0;

    // ---------------------------------------------------------------
    // predictor
    // ---------------------------------------------------------------

    // zero counts as one, anything above the top saturates
    function automatic int unsigned fit_dim(int unsigned v, int unsigned top);
        if (v == 0) return 1;
        return (v > top) ? top : v;
    endfunction

    // store entry that output pixel (x,y) maps to, flipped vertically
    function automatic int unsigned source_index(logic [11:0] x, logic [11:0] y);
        int unsigned sw, sh, dw, dh, cx, cy, sx, sy;
        sw = fit_dim(32'(cfg_src_w), SRC_MAX_W);
        sh = fit_dim(32'(cfg_src_h), SRC_MAX_H);
        dw = fit_dim(32'(cfg_dst_w), DST_DIM_TOP);
        dh = fit_dim(32'(cfg_dst_h), DST_DIM_TOP);
        cx = 32'(x);
        cy = 32'(y);
        // clamp to the last column and row
        if (cx >= dw) cx = dw - 1;
        if (cy >= dh) cy = dh - 1;
        sx = (cx * sw) / dw;
        sy = ((dh - 1 - cy) * sh) / dh;
        return (sy * SRC_MAX_W + sx) % STORE_ENTRIES;
    endfunction

    // applies one item to the mirror, returns the result it causes if any
    function automatic void predict_scaled_pixel(input pixel_req_t r, output bit produces,
                                                 output pixel_result_t res);
        logic [23:0] px;
        logic [7:0]  alpha;
        logic [7:0]  r0, r1, r2;
        bit          below;
        produces = 1'b0;
        res      = '0;
        if (r.func == FUNC_WRITE) begin
            // writes outside the store are dropped
            if (r.x < SRC_MAX_W && r.y < SRC_MAX_H) begin
                frame_mirror[r.y * SRC_MAX_W + r.x]  = {r.c0, r.c1, r.c2};
                store_written[r.y * SRC_MAX_W + r.x] = 1'b1;
            end
            return;
        end
        px    = frame_mirror[source_index(r.x, r.y)];
        r0    = px[23:16] + cfg_offs[7:0];
        r1    = px[15:8]  + cfg_offs[15:8];
        r2    = px[7:0]   + cfg_offs[23:16];
        alpha = ALPHA_BASE + cfg_offs[31:24];
        // a zero threshold never keys
        below = px[23:16] < cfg_key_thr && px[15:8] < cfg_key_thr && px[7:0] < cfg_key_thr;
        if (below) alpha = 8'd0;
        produces  = 1'b1;
        res.word  = {alpha, r0, r1, r2};
        res.keyed = below;
    endfunction

    // ---------------------------------------------------------------
    // stimulus helpers
    // ---------------------------------------------------------------

    function automatic stim_row_t wr_row(logic [11:0] x, logic [11:0] y,
                                         logic [7:0] c0, logic [7:0] c1, logic [7:0] c2);
        stim_row_t row;
        row     = '0;
        row.req = '{FUNC_WRITE, x, y, c0, c1, c2};
        return row;
    endfunction

    // read row checked against the predictor
    function automatic stim_row_t rd_row(logic [11:0] x, logic [11:0] y);
        stim_row_t row;
        row     = '0;
        row.req = '{FUNC_READ, x, y, 8'h00, 8'hFF, 8'h5A};
        return row;
    endfunction

    // read row with the result typed in
    function automatic stim_row_t rd_known(logic [11:0] x, logic [11:0] y,
                                           logic [31:0] word, logic keyed);
        stim_row_t row;
        row          = rd_row(x, y);
        row.has_want = 1'b1;
        row.want     = '{word, keyed};
        return row;
    endfunction

    function automatic stim_row_t reg_row(logic [2:0] idx, logic [31:0] val);
        stim_row_t row;
        row         = '0;
        row.is_reg  = 1'b1;
        row.reg_idx = idx;
        row.reg_val = val;
        return row;
    endfunction

    // source bytes, often at or below the key threshold
    function automatic logic [7:0] rand_chan();
        if ($urandom_range(0, 2) == 0) return 8'($urandom_range(0, cfg_key_thr));
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [8:0] pick_src_dim();
        case ($urandom_range(0, 7))
            0:       return 9'd0;
            1:       return 9'd1;
            2:       return 9'd256;
            3:       return 9'd511;
            4, 5:    return 9'($urandom_range(1, 16));
            default: return 9'($urandom_range(1, 300));
        endcase
    endfunction

    function automatic logic [12:0] pick_dst_dim();
        case ($urandom_range(0, 7))
            0:       return 13'd0;
            1:       return 13'd1;
            2:       return 13'd4096;
            3:       return 13'd8191;
            4, 5:    return 13'($urandom_range(1, 32));
            default: return 13'($urandom_range(1, DST_DIM_TOP));
        endcase
    endfunction

    // output coordinate, mostly inside the output frame, sometimes far beyond
    function automatic logic [11:0] pick_read_coord(int unsigned dim);
        int unsigned top;
        top = (dim > 4096) ? 4095 : dim - 1;
        case ($urandom_range(0, 9))
            0:       return 12'hFFF;
            1:       return 12'($urandom_range(0, 4095));
            2:       return 12'(top);
            default: return 12'($urandom_range(0, top));
        endcase
    endfunction

    function automatic int unsigned pick_idle_pct();
        case ($urandom_range(0, 2))
            0:       return 0;
            1:       return 15;
            default: return 50;
        endcase
    endfunction

    // ---------------------------------------------------------------
    // drivers
    // ---------------------------------------------------------------

    // apb write: setup cycle, access cycle, then the bus is left idle
    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        case (idx)
            REG_SRC_WIDTH:  cfg_src_w   = val[8:0];
            REG_SRC_HEIGHT: cfg_src_h   = val[8:0];
            REG_DST_WIDTH:  cfg_dst_w   = val[12:0];
            REG_DST_HEIGHT: cfg_dst_h   = val[12:0];
            REG_KEY_THRESH: cfg_key_thr = val[7:0];
            REG_COLOR_OFFS: cfg_offs    = val;
            default: ;
        endcase
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic load_config(logic [8:0] sw, logic [8:0] sh, logic [12:0] dw,
                               logic [12:0] dh, logic [7:0] thr, logic [31:0] offs);
        write_reg(REG_SRC_WIDTH, 32'(sw));
        write_reg(REG_SRC_HEIGHT, 32'(sh));
        write_reg(REG_DST_WIDTH, 32'(dw));
        write_reg(REG_DST_HEIGHT, 32'(dh));
        write_reg(REG_KEY_THRESH, 32'(thr));
        write_reg(REG_COLOR_OFFS, offs);
    endtask

    // offer one item, return at the edge where it is taken
    task automatic send_item(pixel_req_t r);
        int unsigned gap;
        gap = 0;
        if (!calm && !tx_rush && $urandom_range(0, 99) < tx_idle_pct)
            gap = $urandom_range(1, 17);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= r.func;
        s_tdata  <= {r.c2, r.c1, r.c0, r.y, r.x};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // predict first, then drive; a typed expectation overrides the prediction
    task automatic run_item(pixel_req_t r, logic has_want, pixel_result_t want);
        bit            produces;
        pixel_result_t res;
        predict_scaled_pixel(r, produces, res);
        if (produces) pixel_expect_q.push_back(has_want ? want : res);
        send_item(r);
    endtask

    // block idle: every result in, and a pipeline's worth of cycles after
    task automatic settle_idle();
        s_tvalid <= 1'b0;
        while (pixel_expect_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // one random phase under the current registers
    task automatic run_phase(int iters, bit pressure);
        pixel_req_t  r;
        pixel_req_t  fill;
        int unsigned idx, sw, sh, dw, dh, rush_left;
        rush_left = 0;
        sw = fit_dim(32'(cfg_src_w), SRC_MAX_W);
        sh = fit_dim(32'(cfg_src_h), SRC_MAX_H);
        dw = fit_dim(32'(cfg_dst_w), DST_DIM_TOP);
        dh = fit_dim(32'(cfg_dst_h), DST_DIM_TOP);
        for (int i = 0; i < iters; i++) begin
            // long receiver hold-off while reads keep coming back to back
            if (pressure && i == iters / 3) begin
                rx_hold_req = 1'b1;
                rush_left   = 16;
            end
            tx_rush = (rush_left != 0);
            r.c0 = rand_chan();
            r.c1 = rand_chan();
            r.c2 = rand_chan();
            if (rush_left != 0 || $urandom_range(0, 99) < 55) begin
                r.func = FUNC_READ;
                r.x    = pick_read_coord(dw);
                r.y    = pick_read_coord(dh);
                idx    = source_index(r.x, r.y);
                // never read an entry that was not written: fill it first
                if (!store_written[idx]) begin
                    fill.func = FUNC_WRITE;
                    fill.x    = 12'(idx % SRC_MAX_W);
                    fill.y    = 12'(idx / SRC_MAX_W);
                    fill.c0   = rand_chan();
                    fill.c1   = rand_chan();
                    fill.c2   = rand_chan();
                    run_item(fill, 1'b0, '0);
                end
                run_item(r, 1'b0, '0);
            end else begin
                r.func = FUNC_WRITE;
                case ($urandom_range(0, 19))
                    // mostly outside the store, dropped by the block
                    0, 1, 2: begin
                        r.x = 12'($urandom_range(0, 4095));
                        r.y = 12'($urandom_range(0, 4095));
                    end
                    // anywhere in the store, also beyond the source size
                    3, 4, 5, 6, 7: begin
                        r.x = 12'($urandom_range(0, SRC_MAX_W - 1));
                        r.y = 12'($urandom_range(0, SRC_MAX_H - 1));
                    end
                    default: begin
                        r.x = 12'($urandom_range(0, sw - 1));
                        r.y = 12'($urandom_range(0, sh - 1));
                    end
                endcase
                run_item(r, 1'b0, '0);
            end
            if (rush_left != 0) rush_left--;
        end
        tx_rush = 1'b0;
    endtask

    // ---------------------------------------------------------------
    // receiver: random stalls, one long hold-off on request
    // ---------------------------------------------------------------
    initial begin : result_sink
        wait (aresetn);
        @(posedge aclk);
        forever begin
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge aclk);
            end else if (!calm && $urandom_range(0, 99) < rx_idle_pct) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    // ---------------------------------------------------------------
    // scoreboard: each taken result against the oldest expectation
    // ---------------------------------------------------------------
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pixel_expect_q.size() == 0) begin
                $display("%0t: result with none owed, expected nothing, got word %h keyed %b",
                         $time, m_tdata, m_tuser[0]);
                mismatch_count++;
            end else begin
                head_px = pixel_expect_q.pop_front();
                if (m_tdata !== head_px.word) begin
                    $display("%0t: pixel_word expected %h got %h", $time, head_px.word, m_tdata);
                    mismatch_count++;
                end
                if (m_tuser[0] !== head_px.keyed) begin
                    $display("%0t: keyed expected %b got %b", $time, head_px.keyed, m_tuser[0]);
                    mismatch_count++;
                end
            end
        end
    end

    // watchdog
    always @(posedge aclk) cycle_count <= cycle_count + 1;

    initial begin : watchdog
        wait (cycle_count >= CYCLE_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // ---------------------------------------------------------------
    // main sequence
    // ---------------------------------------------------------------
    initial begin : main_seq
        logic [7:0]  thr_v;
        logic [31:0] offs_v;

        // after reset: 256x256 to 256x256 is a pure vertical flip, no key, no offsets
        stim_rows.push_back(wr_row(12'd0, 12'd255, 8'h11, 8'h22, 8'h33));
        stim_rows.push_back(wr_row(12'd255, 12'd0, 8'hFF, 8'hFF, 8'hFF));
        stim_rows.push_back(wr_row(12'd0, 12'd0, 8'h00, 8'h00, 8'h00));
        // writes outside the store must not land anywhere
        stim_rows.push_back(wr_row(12'd4095, 12'd0, 8'h01, 8'h02, 8'h03));
        stim_rows.push_back(wr_row(12'd0, 12'd4095, 8'h04, 8'h05, 8'h06));
        stim_rows.push_back(wr_row(12'd256, 12'd256, 8'h07, 8'h08, 8'h09));
        stim_rows.push_back(rd_known(12'd0, 12'd0, 32'hFF112233, 1'b0));
        // far corner clamps to the last column and row
        stim_rows.push_back(rd_known(12'd4095, 12'd4095, 32'hFFFFFFFF, 1'b0));
        // black pixel under zero threshold keeps its alpha
        stim_rows.push_back(rd_known(12'd0, 12'd255, 32'hFF000000, 1'b0));
        stim_rows.push_back(wr_row(12'd128, 12'd64, 8'hA5, 8'h5A, 8'hC3));
        stim_rows.push_back(rd_known(12'd128, 12'd191, 32'hFFA55AC3, 1'b0));
        // overwrite of a written pixel
        stim_rows.push_back(wr_row(12'd0, 12'd255, 8'hAA, 8'hBB, 8'hCC));
        stim_rows.push_back(rd_known(12'd0, 12'd0, 32'hFFAABBCC, 1'b0));
        // offsets wrap mod 256, alpha becomes 0xfe, black keys out
        stim_rows.push_back(reg_row(REG_KEY_THRESH, 32'h80));
        stim_rows.push_back(reg_row(REG_COLOR_OFFS, 32'hFF302010));
        stim_rows.push_back(rd_known(12'd0, 12'd0, 32'hFEBADBFC, 1'b0));
        stim_rows.push_back(rd_known(12'd0, 12'd255, 32'h00102030, 1'b1));
        stim_rows.push_back(rd_known(12'd255, 12'd255, 32'hFE0F1F2F, 1'b0));
        // zero sizes act as one: every read lands on entry 0,0
        stim_rows.push_back(reg_row(REG_SRC_WIDTH, 32'd0));
        stim_rows.push_back(reg_row(REG_SRC_HEIGHT, 32'd0));
        stim_rows.push_back(reg_row(REG_DST_WIDTH, 32'd0));
        stim_rows.push_back(reg_row(REG_DST_HEIGHT, 32'd0));
        stim_rows.push_back(rd_known(12'd4095, 12'd4095, 32'h00102030, 1'b1));
        // oversized source saturates, largest output sizes
        stim_rows.push_back(reg_row(REG_SRC_WIDTH, 32'd511));
        stim_rows.push_back(reg_row(REG_SRC_HEIGHT, 32'd511));
        stim_rows.push_back(reg_row(REG_DST_WIDTH, 32'd8191));
        stim_rows.push_back(reg_row(REG_DST_HEIGHT, 32'd8191));
        stim_rows.push_back(wr_row(12'd127, 12'd255, 8'h01, 8'h02, 8'h03));
        // middle row of the output lands on source row 127
        stim_rows.push_back(wr_row(12'd0, 12'd127, 8'h44, 8'h55, 8'h66));
        stim_rows.push_back(rd_row(12'd4095, 12'd0));
        stim_rows.push_back(rd_row(12'd0, 12'd4095));

        // reset, held and then released
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed part
        tx_idle_pct = 30;
        rx_idle_pct = 30;
        foreach (stim_rows[i]) begin
            if (stim_rows[i].is_reg) begin
                settle_idle();
                write_reg(stim_rows[i].reg_idx, stim_rows[i].reg_val);
            end else begin
                run_item(stim_rows[i].req, stim_rows[i].has_want, stim_rows[i].want);
            end
        end

        // random phases, each under fresh registers; the last one runs without idling
        for (int p = 0; p < NUM_PHASES; p++) begin
            settle_idle();
            if (p == 0) begin
                load_config(9'd256, 9'd256, 13'd4096, 13'd4096, 8'd255, 32'hFFFFFFFF);
            end else begin
                case ($urandom_range(0, 2))
                    0:       thr_v = 8'd0;
                    1:       thr_v = 8'd255;
                    default: thr_v = 8'($urandom_range(0, 255));
                endcase
                case ($urandom_range(0, 2))
                    0:       offs_v = 32'd0;
                    1:       offs_v = 32'hFFFFFFFF;
                    default: offs_v = $urandom;
                endcase
                load_config(pick_src_dim(), pick_src_dim(), pick_dst_dim(), pick_dst_dim(),
                            thr_v, offs_v);
            end
            calm        = (p == NUM_PHASES - 1);
            tx_idle_pct = pick_idle_pct();
            rx_idle_pct = pick_idle_pct();
            run_phase(PHASE_ITERS, p == 1);
        end

        // drain and report
        settle_idle();
        if (mismatch_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
